>>> rtl/firmware_image_xor_swap_codec_macros.svh
// Assertion helpers shared by the codec modules.
`ifndef FIRMWARE_IMAGE_XOR_SWAP_CODEC_MACROS_SVH
`define FIRMWARE_IMAGE_XOR_SWAP_CODEC_MACROS_SVH

// Check a property on an explicit clock and active-low reset.
`define FIXC_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on the block clock and reset.
`define FIXC_ASSERT(lbl, prop, msg) \
  `FIXC_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

>>> rtl/fixc_pkg.sv
package fixc_pkg;

  localparam int PKT_BITS_DEFAULT = 12;
  localparam int CFG_BITS         = 12;
  localparam int WORD_BITS        = 32;
  localparam int POS_BITS         = 4;
  localparam int ROW_BITS         = 3;
  localparam int WORDS_PER_PACKET = 13;
  localparam int QUEUE_DEPTH      = 2;
  localparam int ADDR_BITS        = 4;
  localparam int DATA_BITS        = 32;

  typedef enum logic [1:0] {
    OP_PASS,
    OP_ENCODE,
    OP_DECODE
  } op_e;

  typedef enum logic [1:0] {
    REG_CODEC_MODE,
    REG_FIRST_CODED,
    REG_LAST_CODED
  } reg_idx_e;

  typedef struct packed {
    logic                codec_mode;
    logic [CFG_BITS-1:0] first_coded_packet;
    logic [CFG_BITS-1:0] last_coded_packet;
  } cfg_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] word;
    logic [POS_BITS-1:0]  pos;
    logic [ROW_BITS-1:0]  row;
    op_e                  op;
  } item_t;

  typedef logic [3:0][1:0] row_t;
  typedef logic [3:0][7:0] bytes_t;

  function automatic logic [WORD_BITS-1:0] word_key(logic [POS_BITS-1:0] pos);
    logic [WORD_BITS-1:0] key;
    unique case (pos)
      4'd0:    key = 32'h55aa55aa;
      4'd1:    key = 32'haa55aa55;
      4'd2:    key = 32'h000000ff;
      4'd3:    key = 32'h0000ff00;
      4'd4:    key = 32'h00ff0000;
      4'd5:    key = 32'hff000000;
      4'd7:    key = 32'hffffffff;
      4'd8:    key = 32'h0f0f0f0f;
      4'd9:    key = 32'hf0f0f0f0;
      4'd10:   key = 32'haaaaaaaa;
      4'd11:   key = 32'h55555555;
      default: key = 32'h00000000;
    endcase
    return key;
  endfunction

  function automatic row_t perm_row(logic [ROW_BITS-1:0] idx);
    row_t row;
    unique case (idx)
      3'd0:    row = {2'd3, 2'd2, 2'd1, 2'd0};
      3'd1:    row = {2'd0, 2'd3, 2'd2, 2'd1};
      3'd2:    row = {2'd0, 2'd3, 2'd1, 2'd2};
      3'd3:    row = {2'd0, 2'd1, 2'd2, 2'd3};
      3'd4:    row = {2'd2, 2'd0, 2'd1, 2'd3};
      3'd5:    row = {2'd3, 2'd0, 2'd2, 2'd1};
      3'd6:    row = {2'd0, 2'd1, 2'd3, 2'd2};
      default: row = {2'd3, 2'd1, 2'd2, 2'd0};
    endcase
    return row;
  endfunction

  // Encode direction: input byte k goes to position row[k].
  function automatic bytes_t scatter(bytes_t w, row_t row);
    bytes_t r;
    r = '0;
    for (int k = 0; k < 4; k++) begin
      r[row[k]] = r[row[k]] | w[k];
    end
    return r;
  endfunction

  // Decode direction: output byte k comes from input byte row[k].
  function automatic bytes_t gather(bytes_t w, row_t row);
    bytes_t r;
    for (int k = 0; k < 4; k++) begin
      r[k] = w[row[k]];
    end
    return r;
  endfunction

endpackage

>>> rtl/fixc_front.sv
module fixc_front #(
  parameter int PACKET_COUNT_BITS = fixc_pkg::PKT_BITS_DEFAULT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             accept_i,
  input  logic [fixc_pkg::WORD_BITS-1:0]   word_in_i,
  input  logic                             image_start_i,
  input  fixc_pkg::cfg_t                   cfg_i,
  output fixc_pkg::item_t                  item_o
);

  `include "firmware_image_xor_swap_codec_macros.svh"

  localparam int CmpW = (PACKET_COUNT_BITS > fixc_pkg::CFG_BITS) ?
                        PACKET_COUNT_BITS : fixc_pkg::CFG_BITS;
  localparam logic [fixc_pkg::POS_BITS-1:0] PosWrap =
    fixc_pkg::POS_BITS'(fixc_pkg::WORDS_PER_PACKET);

  logic [fixc_pkg::POS_BITS-1:0]  pos_q, pos_d, pos_base, pos_eff, pos_inc;
  logic [PACKET_COUNT_BITS-1:0]   pkt_q, pkt_d, pkt_eff;
  logic [CmpW-1:0]                pkt_x, first_x, last_x;
  logic                           coded, wrap;

  always_comb begin
    pos_base = image_start_i ? '0 : pos_q;
    pkt_eff  = image_start_i ? '0 : pkt_q;
    pos_eff  = (pos_base >= PosWrap) ? '0 : pos_base;
    pkt_x    = CmpW'(pkt_eff);
    first_x  = CmpW'(cfg_i.first_coded_packet);
    last_x   = CmpW'(cfg_i.last_coded_packet);
    coded    = (pkt_x >= first_x) && (pkt_x <= last_x);
    pos_inc  = pos_eff + 1'b1;
    wrap     = (pos_inc == PosWrap);
  end

  always_comb begin
    item_o.word = word_in_i;
    item_o.pos  = pos_eff;
    item_o.row  = pkt_eff[fixc_pkg::ROW_BITS-1:0];
    if (!coded) begin
      item_o.op = fixc_pkg::OP_PASS;
    end else if (cfg_i.codec_mode) begin
      item_o.op = fixc_pkg::OP_DECODE;
    end else begin
      item_o.op = fixc_pkg::OP_ENCODE;
    end
  end

  always_comb begin
    pos_d = pos_q;
    pkt_d = pkt_q;
    if (accept_i) begin
      pos_d = wrap ? '0 : pos_inc;
      pkt_d = (wrap && (pkt_eff != '1)) ? pkt_eff + 1'b1 : pkt_eff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      pkt_q <= '0;
    end else begin
      pos_q <= pos_d;
      pkt_q <= pkt_d;
    end
  end

  `FIXC_ASSERT(a_pos_in_packet, (pos_q < PosWrap), "word position left its packet")
  `FIXC_ASSERT(a_pkt_no_wrap, accept_i && !image_start_i |=> pkt_q >= $past(pkt_q), "count fell")

endmodule

>>> rtl/fixc_queue.sv
module fixc_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_i,
  input  fixc_pkg::item_t wr_item_i,
  output logic            full_o,
  input  logic            rd_i,
  output logic            valid_o,
  output fixc_pkg::item_t rd_item_o
);

  `include "firmware_image_xor_swap_codec_macros.svh"

  localparam int Depth = fixc_pkg::QUEUE_DEPTH;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  fixc_pkg::item_t        mem_q [Depth];
  logic [PtrW-1:0]        wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   do_wr, do_rd;

  assign full_o    = (cnt_q == CntW'(Depth));
  assign valid_o   = (cnt_q != '0);
  assign rd_item_o = mem_q[rd_ptr_q];
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && valid_o;

  always_comb begin
    wr_ptr_d = do_wr ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_rd ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + CntW'(do_wr) - CntW'(do_rd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

  `FIXC_ASSERT(a_cnt_bound, (cnt_q <= CntW'(Depth)), "queue count past depth")
  `FIXC_ASSERT(a_ptr_gap, (cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q), "empty queue with pointer gap")

endmodule

>>> rtl/fixc_back.sv
module fixc_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           item_valid_i,
  input  fixc_pkg::item_t                item_i,
  output logic                           item_take_o,
  output logic                           empty_o,
  input  logic                           pop_i,
  output logic [fixc_pkg::WORD_BITS-1:0] word_out_o
);

  `include "firmware_image_xor_swap_codec_macros.svh"

  logic                           out_valid_q, out_valid_d;
  logic [fixc_pkg::WORD_BITS-1:0] word_q, result;
  logic [fixc_pkg::WORD_BITS-1:0] key;
  fixc_pkg::row_t                 row;

  always_comb begin
    key = fixc_pkg::word_key(item_i.pos);
    row = fixc_pkg::perm_row(item_i.row);
    unique case (item_i.op)
      fixc_pkg::OP_ENCODE: result = fixc_pkg::scatter(item_i.word, row) ^ key;
      fixc_pkg::OP_DECODE: result = fixc_pkg::gather(item_i.word ^ key, row);
      default:             result = item_i.word;
    endcase
  end

  assign item_take_o = item_valid_i && (!out_valid_q || pop_i);
  assign empty_o     = !out_valid_q;
  assign word_out_o  = word_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (item_take_o) begin
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_take_o) begin
      word_q <= result;
    end
  end

  `FIXC_ASSERT(a_take_needs_slot, item_take_o |-> (!out_valid_q || pop_i), "item taken over a held result")
  `FIXC_ASSERT(a_take_fills, item_take_o |=> out_valid_q, "taken item not presented")

endmodule

>>> rtl/firmware_image_xor_swap_codec.sv
// Firmware image word codec.
// Input channel: drive word_in_i and image_start_i with push high; the word is
// taken at a clock edge where full is low. image_start_i marks word 0 of
// packet 0 and restarts the word and packet counters from that word.
// Result channel: while empty is low, word_out_o holds the oldest result; it
// is taken at a clock edge where pop is high.
// Path: a pushed word is written into the queue, then transformed into the output register.
// Throughput: one word per cycle while pop keeps up, set by the two-entry queue
// between the classifier and the transform stage plus the single output register.
// A stalled receiver fills the output register and then the queue; full rises
// once both hold items, and no item is lost.
// Configuration (APB, byte address 4*i): codec_mode, first_coded_packet,
// last_coded_packet. Write only while no item is in flight.
// Reset: counters cleared, queue and output emptied, registers return to
// encode mode with packets 10 through 100 coded.
module firmware_image_xor_swap_codec #(
  parameter int PACKET_COUNT_BITS = fixc_pkg::PKT_BITS_DEFAULT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [fixc_pkg::ADDR_BITS-1:0]   paddr,
  input  logic [fixc_pkg::DATA_BITS-1:0]   pwdata,
  output logic [fixc_pkg::DATA_BITS-1:0]   prdata,
  output logic                             pready,
  input  logic                             push,
  output logic                             full,
  input  logic [fixc_pkg::WORD_BITS-1:0]   word_in_i,
  input  logic                             image_start_i,
  output logic                             empty,
  input  logic                             pop,
  output logic [fixc_pkg::WORD_BITS-1:0]   word_out_o
);

  fixc_pkg::cfg_t     cfg_q, cfg_d;
  fixc_pkg::reg_idx_e reg_idx;
  fixc_pkg::item_t    front_item, queue_item;
  logic               cfg_wr, accept, queue_valid, queue_take;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = fixc_pkg::reg_idx_e'(paddr[fixc_pkg::ADDR_BITS-1:2]);
  assign accept  = push && !full;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      unique case (reg_idx)
        fixc_pkg::REG_CODEC_MODE:  cfg_d.codec_mode = pwdata[0];
        fixc_pkg::REG_FIRST_CODED:
          cfg_d.first_coded_packet = pwdata[fixc_pkg::CFG_BITS-1:0];
        fixc_pkg::REG_LAST_CODED:
          cfg_d.last_coded_packet = pwdata[fixc_pkg::CFG_BITS-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      fixc_pkg::REG_CODEC_MODE:
        prdata = fixc_pkg::DATA_BITS'(cfg_q.codec_mode);
      fixc_pkg::REG_FIRST_CODED:
        prdata = fixc_pkg::DATA_BITS'(cfg_q.first_coded_packet);
      fixc_pkg::REG_LAST_CODED:
        prdata = fixc_pkg::DATA_BITS'(cfg_q.last_coded_packet);
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.codec_mode         <= 1'b0;
      cfg_q.first_coded_packet <= fixc_pkg::CFG_BITS'(10);
      cfg_q.last_coded_packet  <= fixc_pkg::CFG_BITS'(100);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  fixc_front #(
    .PACKET_COUNT_BITS(PACKET_COUNT_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .word_in_i     (word_in_i),
    .image_start_i (image_start_i),
    .cfg_i         (cfg_q),
    .item_o        (front_item)
  );

  fixc_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (push),
    .wr_item_i (front_item),
    .full_o    (full),
    .rd_i      (queue_take),
    .valid_o   (queue_valid),
    .rd_item_o (queue_item)
  );

  fixc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (queue_valid),
    .item_i       (queue_item),
    .item_take_o  (queue_take),
    .empty_o      (empty),
    .pop_i        (pop),
    .word_out_o   (word_out_o)
  );

endmodule
